/* rtl/afs_pkg.sv */
`timescale 1ns / 1ps
package afs_pkg;

   localparam int unsigned MAX_DIM   = 4096;
   localparam int unsigned DIM_W     = 13;
   localparam int unsigned COORD_W   = 12;
   localparam int unsigned INDEX_W   = 24;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned PROD_W    = COORD_W + DIM_W;
   localparam int unsigned QUOT_W    = DIM_W;
   localparam int unsigned LNUM_W    = 2 * DIM_W;

   typedef logic [DIM_W-1:0]   dim_type;
   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type REG_VIEW_W  = 2'd0;
   localparam csr_idx_type REG_VIEW_H  = 2'd1;
   localparam csr_idx_type REG_IMAGE_W = 2'd2;
   localparam csr_idx_type REG_IMAGE_H = 2'd3;

   typedef struct packed {
      logic      busy;
      logic      active;
      dim_type   image_w;
      dim_type   image_h;
      dim_type   drawn_w;
      dim_type   drawn_h;
      coord_type off_x;
      coord_type off_y;
   } layout_type;

   // saturate a size register at the largest supported dimension
   function automatic dim_type clamp_dim(input dim_type v);
      if (32'(v) > MAX_DIM) begin
         return DIM_W'(MAX_DIM);
      end
      return v;
   endfunction

endpackage

/* rtl/afs_if.sv */
`timescale 1ns / 1ps
interface afs_req_if;
   import afs_pkg::*;

   logic      valid;
   logic      ready;
   coord_type dest_x;
   coord_type dest_y;

   modport source (output valid, output dest_x, output dest_y, input ready);
   modport sink (input valid, input dest_x, input dest_y, output ready);
endinterface

interface afs_rsp_if;
   import afs_pkg::*;

   logic      valid;
   logic      ready;
   logic      active;
   logic      inside_res;
   index_type source_index;

   modport source (output valid, output active, output inside_res, output source_index,
                   input ready);
   modport sink (input valid, input active, input inside_res, input source_index,
                 output ready);
endinterface

/* rtl/afs_layout.sv */
`timescale 1ns / 1ps
module afs_layout (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  afs_pkg::csr_idx_type csr_index,
   input  afs_pkg::dim_type     csr_wdata,
   output afs_pkg::layout_type  layout
);
   import afs_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_DIV1 = 3'd2;
   localparam logic [2:0] ST_CHK  = 3'd3;
   localparam logic [2:0] ST_DIV2 = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   localparam int unsigned CNT_W = $clog2(LNUM_W);

   dim_type vw_ff, vh_ff, iw_ff, ih_ff;
   dim_type vw_c, vh_c, iw_c, ih_c;
   logic    sizes_ok;

   logic [2:0]        state_ff, state_in;
   logic [LNUM_W-1:0] num_ff, num_in, num_next;
   dim_type           rem_ff, rem_in, rem_next;
   dim_type           den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   dim_type           dw_ff, dw_in, dh_ff, dh_in;
   layout_type        lay_ff, lay_in;

   logic [DIM_W:0] trial;
   logic           take;

   assign vw_c = clamp_dim(vw_ff);
   assign vh_c = clamp_dim(vh_ff);
   assign iw_c = clamp_dim(iw_ff);
   assign ih_c = clamp_dim(ih_ff);
   assign sizes_ok = (vw_c != '0) && (vh_c != '0) && (iw_c != '0) && (ih_c != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         vw_ff <= '0;
         vh_ff <= '0;
         iw_ff <= '0;
         ih_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_VIEW_W:  vw_ff <= csr_wdata;
            REG_VIEW_H:  vh_ff <= csr_wdata;
            REG_IMAGE_W: iw_ff <= csr_wdata;
            REG_IMAGE_H: ih_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // restoring divider, one quotient bit per cycle; quotient shifts into num
   assign trial    = {rem_ff, num_ff[LNUM_W-1]};
   assign take     = trial >= {1'b0, den_ff};
   assign rem_next = take ? DIM_W'(trial - {1'b0, den_ff}) : trial[DIM_W-1:0];
   assign num_next = {num_ff[LNUM_W-2:0], take};

   always_comb begin
      dim_type        dwf;
      dim_type        dhf;
      dim_type        xdiff;
      dim_type        ydiff;
      state_in = state_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      dw_in    = dw_ff;
      dh_in    = dh_ff;
      lay_in   = lay_ff;
      dwf      = (dw_ff == '0) ? DIM_W'(1) : dw_ff;
      dhf      = (dh_ff == '0) ? DIM_W'(1) : dh_ff;
      xdiff    = vw_c - dwf;
      ydiff    = vh_c - dhf;
      unique case (state_ff)
         ST_IDLE: ;
         ST_MUL1: begin
            if (!sizes_ok) begin
               lay_in   = '0;
               state_in = ST_IDLE;
            end else begin
               num_in   = LNUM_W'(ih_c) * LNUM_W'(vw_c);
               rem_in   = '0;
               den_in   = iw_c;
               cnt_in   = CNT_W'(LNUM_W - 1);
               dw_in    = vw_c;
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            num_in = num_next;
            rem_in = rem_next;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (num_ff > LNUM_W'(vh_c)) begin
               dh_in    = vh_c;
               num_in   = LNUM_W'(iw_c) * LNUM_W'(vh_c);
               rem_in   = '0;
               den_in   = ih_c;
               cnt_in   = CNT_W'(LNUM_W - 1);
               state_in = ST_DIV2;
            end else begin
               dh_in    = num_ff[DIM_W-1:0];
               state_in = ST_FIN;
            end
         end
         ST_DIV2: begin
            num_in = num_next;
            rem_in = rem_next;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               dw_in    = num_next[DIM_W-1:0];
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            lay_in.busy    = 1'b0;
            lay_in.active  = 1'b1;
            lay_in.image_w = iw_c;
            lay_in.image_h = ih_c;
            lay_in.drawn_w = dwf;
            lay_in.drawn_h = dhf;
            lay_in.off_x   = COORD_W'(xdiff >> 1);
            lay_in.off_y   = COORD_W'(ydiff >> 1);
            state_in       = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      // restart on every register write
      if (csr_we) begin
         state_in = ST_MUL1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lay_ff   <= '0;
      end else begin
         state_ff <= state_in;
         lay_ff   <= lay_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      dw_ff  <= dw_in;
      dh_ff  <= dh_in;
   end

   always_comb begin
      layout      = lay_ff;
      layout.busy = (state_ff != ST_IDLE);
   end

endmodule

/* rtl/afs_pix_pipe.sv */
`timescale 1ns / 1ps
module afs_pix_pipe (
   input  logic                clock,
   input  logic                reset,
   input  afs_pkg::layout_type layout,
   input  logic                in_valid,
   output logic                in_ready,
   input  afs_pkg::coord_type  dest_x,
   input  afs_pkg::coord_type  dest_y,
   afs_rsp_if.source           rsp
);
   import afs_pkg::*;

   localparam int unsigned STG_ENTRY = 0;
   localparam int unsigned STG_OFS   = 1;
   localparam int unsigned STG_MUL   = 2;
   localparam int unsigned STG_DIV0  = 3;
   localparam int unsigned STG_ROW   = STG_DIV0 + QUOT_W;
   localparam int unsigned STG_OUT   = STG_ROW + 1;
   localparam int unsigned NST       = STG_OUT + 1;

   logic [NST-1:0] v_ff, v_src, ld;
   logic [NST-1:1] in_ff, in_src;

   coord_type dx_ff, dy_ff;
   coord_type x_ff, y_ff;
   logic [PROD_W-1:0] px_ff, py_ff;
   dim_type rx_ff [QUOT_W];
   dim_type ry_ff [QUOT_W];
   dim_type nx_ff [QUOT_W];
   dim_type ny_ff [QUOT_W];
   logic [LNUM_W-1:0] row_ff;
   dim_type   sx_ff;
   index_type idx_ff;

   coord_type x_d, y_d;
   logic      inside_d;

   // a stage loads when it or a later stage is empty, or when rsp.ready is high
   for (genvar i = 0; i < NST; i++) begin : g_ld
      assign ld[i] = rsp.ready | ~(&v_ff[NST-1:i]);
   end

   assign in_ready = ld[STG_ENTRY];
   assign v_src    = {v_ff[NST-2:0], in_valid};
   assign in_src   = {in_ff[NST-2:1], inside_d};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NST; i++) begin
            if (ld[i]) begin
               v_ff[i] <= v_src[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = STG_OFS; i < NST; i++) begin
         if (ld[i]) begin
            in_ff[i] <= in_src[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[STG_ENTRY]) begin
         dx_ff <= dest_x;
         dy_ff <= dest_y;
      end
   end

   assign x_d = dx_ff - layout.off_x;
   assign y_d = dy_ff - layout.off_y;
   assign inside_d = layout.active
                   && (dx_ff >= layout.off_x) && (DIM_W'(x_d) < layout.drawn_w)
                   && (dy_ff >= layout.off_y) && (DIM_W'(y_d) < layout.drawn_h);

   always_ff @(posedge clock) begin
      if (ld[STG_OFS]) begin
         x_ff         <= x_d;
         y_ff         <= y_d;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[STG_MUL]) begin
         px_ff <= PROD_W'(x_ff) * PROD_W'(layout.image_w);
         py_ff <= PROD_W'(y_ff) * PROD_W'(layout.image_h);
      end
   end

   // one quotient bit per stage; for inside beats the remainder stays below the divisor
   for (genvar k = 0; k < QUOT_W; k++) begin : g_div
      dim_type        rx_src, ry_src, nx_src, ny_src;
      logic [DIM_W:0] tx, ty;
      logic           kx, ky;

      if (k == 0) begin : g_first
         assign rx_src = DIM_W'(px_ff[PROD_W-1:QUOT_W]);
         assign ry_src = DIM_W'(py_ff[PROD_W-1:QUOT_W]);
         assign nx_src = px_ff[QUOT_W-1:0];
         assign ny_src = py_ff[QUOT_W-1:0];
      end else begin : g_next
         assign rx_src = rx_ff[k-1];
         assign ry_src = ry_ff[k-1];
         assign nx_src = nx_ff[k-1];
         assign ny_src = ny_ff[k-1];
      end

      assign tx = {rx_src, nx_src[QUOT_W-1]};
      assign ty = {ry_src, ny_src[QUOT_W-1]};
      assign kx = tx >= {1'b0, layout.drawn_w};
      assign ky = ty >= {1'b0, layout.drawn_h};

      always_ff @(posedge clock) begin
         if (ld[STG_DIV0 + k]) begin
            rx_ff[k] <= kx ? DIM_W'(tx - {1'b0, layout.drawn_w}) : tx[DIM_W-1:0];
            ry_ff[k] <= ky ? DIM_W'(ty - {1'b0, layout.drawn_h}) : ty[DIM_W-1:0];
            nx_ff[k] <= {nx_src[QUOT_W-2:0], kx};
            ny_ff[k] <= {ny_src[QUOT_W-2:0], ky};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[STG_ROW]) begin
         row_ff <= LNUM_W'(ny_ff[QUOT_W-1]) * LNUM_W'(layout.image_w);
         sx_ff  <= nx_ff[QUOT_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (ld[STG_OUT]) begin
         idx_ff <= in_ff[STG_ROW] ? INDEX_W'(row_ff + LNUM_W'(sx_ff)) : '0;
      end
   end

   assign rsp.valid        = v_ff[STG_OUT];
   assign rsp.active       = layout.active;
   assign rsp.inside_res   = in_ff[STG_OUT];
   assign rsp.source_index = idx_ff;

endmodule

/* rtl/aspect_fit_nearest_scaler.sv */
`timescale 1ns / 1ps
// Aspect-fit nearest-neighbor scaler address generator.
// Program view width/height and image width/height through the csr_ write
// port (index 0..3). Each write restarts the layout unit, which recomputes
// the drawn rectangle and centering offsets with a shared one-bit-per-cycle
// divider; a second divide runs when the height overflows, and none runs
// when any size is zero. req.ready stays low while the layout is busy.
// Request beats carry dest_x/dest_y; each yields one response beat with
// active, inside_res and source_index (row-major, zero when outside).
// The pixel path is an 18-stage pipeline. A new beat is taken every cycle
// while rsp.ready is high and the layout is not busy. The per-pixel dividers
// resolve one quotient bit per stage, so they set most of the pipeline depth.
// When rsp.ready drops, stages fill up behind the held output and bubbles
// close; req.ready falls only once every stage holds a beat.
// Synchronous reset clears the size registers, the layout (active 0) and
// all stage valid bits.
module aspect_fit_nearest_scaler (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  afs_pkg::csr_idx_type csr_index,
   input  afs_pkg::dim_type     csr_wdata,
   afs_req_if.sink              req,
   afs_rsp_if.source            rsp
);
   import afs_pkg::*;

   layout_type layout;
   logic       pipe_ready;
   logic       pipe_valid;

   afs_layout u_layout (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .layout    (layout)
   );

   // hold off requests while the layout is being recomputed
   assign pipe_valid = req.valid & ~layout.busy;
   assign req.ready  = pipe_ready & ~layout.busy;

   afs_pix_pipe u_pix_pipe (
      .clock    (clock),
      .reset    (reset),
      .layout   (layout),
      .in_valid (pipe_valid),
      .in_ready (pipe_ready),
      .dest_x   (req.dest_x),
      .dest_y   (req.dest_y),
      .rsp      (rsp)
   );

endmodule
